// ===== rtl/hex_text_profile_decoder_defines.svh =====
// Assertion macros used by the checker file of the profile decoder.
`ifndef HEX_TEXT_PROFILE_DECODER_DEFINES_SVH
`define HEX_TEXT_PROFILE_DECODER_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define HTPD_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define HTPD_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/htpd_pkg.sv =====
// Types, constants and character codes of the hex text profile decoder.
package htpd_pkg;

    localparam int LENGTH_BITS = 24;
    localparam int NIBBLE_BITS = LENGTH_BITS + 1;
    localparam int DECL_W      = 24;

    localparam logic [LENGTH_BITS-1:0] COUNT_MAX = {LENGTH_BITS{1'b1}};

    localparam logic [7:0] CHAR_NUL   = 8'h00;
    localparam logic [7:0] CHAR_NL    = 8'h0a;
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_0     = 8'h30;
    localparam logic [7:0] CHAR_9     = 8'h39;
    localparam logic [7:0] CHAR_A     = 8'h61;
    localparam logic [7:0] CHAR_F     = 8'h66;

    localparam logic [1:0] KIND_BYTE  = 2'd0;
    localparam logic [1:0] KIND_LEN   = 2'd1;
    localparam logic [1:0] KIND_ZERO  = 2'd2;
    localparam logic [1:0] KIND_EMPTY = 2'd3;

    typedef enum logic [2:0] {
        PH_IDLE     = 3'd0,
        PH_SEEK_NL  = 3'd1,
        PH_SKIP_WS  = 3'd2,
        PH_DIGITS   = 3'd3,
        PH_SEEK_SEP = 3'd4,
        PH_HEX      = 3'd5
    } phase_t;

    typedef struct packed {
        logic [7:0] text_char;
        logic       start_req;
    } in_item_t;

    typedef struct packed {
        logic [1:0]        kind;
        logic [7:0]        data_byte;
        logic [DECL_W-1:0] declared_length;
        logic              last;
    } out_item_t;

    typedef struct packed {
        phase_t                  phase;
        logic [LENGTH_BITS-1:0]  byte_count;
        logic [NIBBLE_BITS-1:0]  nibbles_left;
        logic [3:0]              high_nibble;
        logic                    odd_nibble;
    } state_t;

    typedef struct packed {
        logic      valid;
        out_item_t item;
    } step_res_t;

endpackage

// ===== rtl/htpd_step.sv =====
// One-character state update of the profile decoder: next state and optional result.
module htpd_step
(
    input  htpd_pkg::state_t    cur,
    input  htpd_pkg::in_item_t  ch,
    output htpd_pkg::state_t    nxt,
    output htpd_pkg::step_res_t res
);
    import htpd_pkg::*;

    localparam int CW = LENGTH_BITS + 4;

    logic [7:0]             c;
    logic                   is_nul;
    logic                   is_break;
    logic                   is_dig;
    logic                   is_hexl;
    logic [3:0]             nib_val;
    logic [LENGTH_BITS-1:0] base;
    logic [CW-1:0]          prod;
    logic [LENGTH_BITS-1:0] sat;
    logic                   do_sep;
    logic [NIBBLE_BITS-1:0] nib_dec;

    assign c        = ch.text_char;
    assign is_nul   = (c == CHAR_NUL);
    assign is_break = (c == CHAR_SPACE) || (c == CHAR_NL);
    assign is_dig   = c inside {[CHAR_0:CHAR_9]};
    assign is_hexl  = c inside {[CHAR_A:CHAR_F]};
    assign nib_val  = is_dig ? c[3:0] : c[3:0] + 4'd9;

    // Count field restarts when the first non-blank arrives
    assign base = (cur.phase == PH_SKIP_WS) ? '0 : cur.byte_count;
    assign prod = (CW'(base) << 3) + (CW'(base) << 1) + CW'(c[3:0]);
    assign sat  = (|prod[CW-1:LENGTH_BITS]) ? COUNT_MAX : prod[LENGTH_BITS-1:0];

    assign nib_dec = (cur.nibbles_left != '0) ? cur.nibbles_left - NIBBLE_BITS'(1)
                                              : cur.nibbles_left;

    always_comb
    begin
        nxt    = cur;
        res    = '0;
        do_sep = 1'b0;
        if (ch.start_req)
        begin
            nxt.phase        = PH_SEEK_NL;
            nxt.byte_count   = '0;
            nxt.nibbles_left = '0;
            nxt.high_nibble  = '0;
            nxt.odd_nibble   = 1'b0;
        end
        else
        begin
            case (cur.phase)
                PH_SEEK_NL:
                begin
                    if (is_nul)
                    begin
                        nxt.phase     = PH_IDLE;
                        res.valid     = 1'b1;
                        res.item.kind = KIND_EMPTY;
                    end
                    else if (c == CHAR_NL)
                    begin
                        nxt.phase = PH_SKIP_WS;
                    end
                end
                PH_SKIP_WS:
                begin
                    if (!(is_nul || is_break))
                    begin
                        nxt.byte_count = '0;
                        if (is_dig)
                        begin
                            nxt.byte_count = sat;
                            nxt.phase      = PH_DIGITS;
                        end
                        else
                        begin
                            do_sep = 1'b1;
                        end
                    end
                end
                PH_DIGITS:
                begin
                    if (is_dig)
                    begin
                        nxt.byte_count = sat;
                    end
                    else
                    begin
                        do_sep = 1'b1;
                    end
                end
                PH_SEEK_SEP:
                begin
                    do_sep = 1'b1;
                end
                PH_HEX:
                begin
                    if (is_nul)
                    begin
                        nxt.phase     = PH_IDLE;
                        res.valid     = 1'b1;
                        res.item.kind = KIND_EMPTY;
                    end
                    else if (is_dig || is_hexl)
                    begin
                        nxt.nibbles_left = nib_dec;
                        if (!cur.odd_nibble)
                        begin
                            nxt.high_nibble = nib_val;
                            nxt.odd_nibble  = 1'b1;
                        end
                        else
                        begin
                            nxt.odd_nibble     = 1'b0;
                            res.valid          = 1'b1;
                            res.item.kind      = KIND_BYTE;
                            res.item.data_byte = {cur.high_nibble, nib_val};
                            res.item.last      = (nib_dec == '0);
                            if (nib_dec == '0)
                            begin
                                nxt.phase = PH_IDLE;
                            end
                        end
                    end
                end
                default:
                begin
                    nxt = cur;
                end
            endcase

            // Separator handling, also reached with the character that ended the digits
            if (do_sep)
            begin
                if (is_nul)
                begin
                    nxt.phase     = PH_IDLE;
                    res.valid     = 1'b1;
                    res.item.kind = KIND_EMPTY;
                end
                else if (is_break)
                begin
                    res.valid = 1'b1;
                    if (nxt.byte_count == '0)
                    begin
                        nxt.phase     = PH_IDLE;
                        res.item.kind = KIND_ZERO;
                    end
                    else
                    begin
                        nxt.phase                = PH_HEX;
                        nxt.nibbles_left         = {nxt.byte_count, 1'b0};
                        nxt.odd_nibble           = 1'b0;
                        nxt.high_nibble          = '0;
                        res.item.kind            = KIND_LEN;
                        res.item.declared_length = DECL_W'(nxt.byte_count);
                    end
                end
                else
                begin
                    nxt.phase = PH_SEEK_SEP;
                end
            end
        end
    end

endmodule

// ===== rtl/hex_text_profile_decoder.sv =====
// Hex text profile decoder, top level: decoder state and result register.
// Takes one character per cycle and gives at most one result per character. Each
// accepted character updates the decoder state in the same cycle, and any result
// lands in a single output register; a new character is taken whenever that
// register is empty or is being read in the same cycle, so with out_ready held
// high the block runs at one character per clock, with each result registered.
// A character with start_req set begins a new profile and gives no result.
module hex_text_profile_decoder
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  htpd_pkg::in_item_t  in_data,
    output logic                out_valid,
    input  logic                out_ready,
    output htpd_pkg::out_item_t out_data
);
    import htpd_pkg::*;

    state_t    state_reg;
    state_t    state_next;
    step_res_t step_res;
    logic      out_valid_reg;
    out_item_t out_data_reg;
    logic      in_fire;

    assign in_ready = !out_valid_reg || out_ready;
    assign in_fire  = in_valid && in_ready;

    htpd_step u_step
    (
        .cur (state_reg),
        .ch  (in_data),
        .nxt (state_next),
        .res (step_res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg.phase        <= PH_IDLE;
            state_reg.byte_count   <= '0;
            state_reg.nibbles_left <= '0;
            state_reg.high_nibble  <= '0;
            state_reg.odd_nibble   <= 1'b0;
            out_valid_reg          <= 1'b0;
        end
        else
        begin
            if (in_fire)
            begin
                state_reg <= state_next;
            end
            // Load a new result, or drop the one just taken
            if (in_fire && step_res.valid)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire && step_res.valid)
        begin
            out_data_reg <= step_res.item;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

// ===== rtl/htpd_checker.sv =====
// Port-level checker of the profile decoder and its bind to the top level.
`include "hex_text_profile_decoder_defines.svh"

module htpd_checker
(
    input logic                clk,
    input logic                rst_n,
    input logic                in_valid,
    input logic                in_ready,
    input htpd_pkg::in_item_t  in_data,
    input logic                out_valid,
    input logic                out_ready,
    input htpd_pkg::out_item_t out_data
);
    import htpd_pkg::*;

    `HTPD_ASSERT_NEXT(a_out_hold, out_valid && !out_ready,
        out_valid && $stable(out_data), "result changed while stalled")
    `HTPD_ASSERT_NOW(a_ready_when_empty, !out_valid, in_ready,
        "input stalled with empty result register")
    `HTPD_ASSERT_NEXT(a_start_silent,
        in_valid && in_ready && in_data.start_req && (!out_valid || out_ready),
        !out_valid, "start item produced a result")
    `HTPD_ASSERT_NOW(a_last_on_byte, out_valid && out_data.last,
        out_data.kind == KIND_BYTE, "last set on a non-byte result")
    `HTPD_ASSERT_NOW(a_len_nonzero, out_valid && out_data.kind == KIND_LEN,
        out_data.declared_length != '0, "zero declared length reported")

endmodule

bind hex_text_profile_decoder htpd_checker u_htpd_checker (.*);

// ===== verif/hex_text_profile_decoder_tb.sv =====
// Testbench of the hex text profile decoder: directed and random profiles checked by a scoreboard.
`timescale 1ns / 100ps

module hex_text_profile_decoder_tb;
    import htpd_pkg::*;

    localparam int ITEM_TARGET  = 1350;
    localparam int STALL_LIMIT  = 2000;
    localparam int DRAIN_CYCLES = 10;

    localparam logic [7:0] BLANKS [3] = '{CHAR_NUL, CHAR_SPACE, CHAR_NL};

    // Tracks the decoder state and holds the results it should give, oldest first.
    class profile_scoreboard;
        phase_t                 phase        = PH_IDLE;
        logic [LENGTH_BITS-1:0] byte_count   = '0;
        logic [NIBBLE_BITS-1:0] nibbles_left = '0;
        logic [3:0]             high_nibble  = '0;
        logic                   odd_nibble   = 1'b0;
        out_item_t              expected_q[$];
        int                     errors       = 0;

        // Space or newline ends the count; anything else but NUL is skipped.
        function bit separator_step(logic [7:0] c, output out_item_t r);
            r = '0;
            if (c == CHAR_NUL)
            begin
                phase  = PH_IDLE;
                r.kind = KIND_EMPTY;
                return 1'b1;
            end
            if (c == CHAR_SPACE || c == CHAR_NL)
            begin
                if (byte_count == '0)
                begin
                    phase  = PH_IDLE;
                    r.kind = KIND_ZERO;
                    return 1'b1;
                end
                phase             = PH_HEX;
                nibbles_left      = {byte_count, 1'b0};
                odd_nibble        = 1'b0;
                high_nibble       = '0;
                r.kind            = KIND_LEN;
                r.declared_length = DECL_W'(byte_count);
                return 1'b1;
            end
            phase = PH_SEEK_SEP;
            return 1'b0;
        endfunction

        function bit digit_step(logic [7:0] c, output out_item_t r);
            longint unsigned acc;
            r = '0;
            if (c >= CHAR_0 && c <= CHAR_9)
            begin
                acc = byte_count;
                acc = acc * 10 + (c - CHAR_0);
                if (acc > COUNT_MAX)
                    acc = COUNT_MAX;
                byte_count = acc[LENGTH_BITS-1:0];
                phase      = PH_DIGITS;
                return 1'b0;
            end
            return separator_step(c, r);
        endfunction

        function void note_input(in_item_t it);
            out_item_t  r;
            bit         has;
            logic [7:0] c;
            logic [3:0] nib;
            bit         is_hex;
            c      = it.text_char;
            has    = 1'b0;
            r      = '0;
            is_hex = 1'b1;
            nib    = '0;
            if (it.start_req)
            begin
                phase        = PH_SEEK_NL;
                byte_count   = '0;
                nibbles_left = '0;
                high_nibble  = '0;
                odd_nibble   = 1'b0;
            end
            else
            begin
                case (phase)
                    PH_SEEK_NL:
                    begin
                        if (c == CHAR_NUL)
                        begin
                            phase  = PH_IDLE;
                            r.kind = KIND_EMPTY;
                            has    = 1'b1;
                        end
                        else if (c == CHAR_NL)
                            phase = PH_SKIP_WS;
                    end
                    PH_SKIP_WS:
                    begin
                        if (!(c == CHAR_NUL || c == CHAR_SPACE || c == CHAR_NL))
                        begin
                            byte_count = '0;
                            has        = digit_step(c, r);
                        end
                    end
                    PH_DIGITS:
                        has = digit_step(c, r);
                    PH_SEEK_SEP:
                        has = separator_step(c, r);
                    PH_HEX:
                    begin
                        if (c >= CHAR_0 && c <= CHAR_9)
                            nib = 4'(c - CHAR_0);
                        else if (c >= CHAR_A && c <= CHAR_F)
                            nib = 4'(c - CHAR_A + 8'd10);
                        else
                            is_hex = 1'b0;
                        if (c == CHAR_NUL)
                        begin
                            phase  = PH_IDLE;
                            r.kind = KIND_EMPTY;
                            has    = 1'b1;
                        end
                        else if (is_hex)
                        begin
                            if (nibbles_left != '0)
                                nibbles_left = nibbles_left - 1'b1;
                            if (!odd_nibble)
                            begin
                                high_nibble = nib;
                                odd_nibble  = 1'b1;
                            end
                            else
                            begin
                                odd_nibble  = 1'b0;
                                r.kind      = KIND_BYTE;
                                r.data_byte = {high_nibble, nib};
                                if (nibbles_left == '0)
                                begin
                                    phase  = PH_IDLE;
                                    r.last = 1'b1;
                                end
                                has = 1'b1;
                            end
                        end
                    end
                    default:
                        ;
                endcase
            end
            if (has)
                expected_q.push_back(r);
        endfunction

        function void check_result(out_item_t got);
            out_item_t want;
            if (expected_q.size() == 0)
            begin
                $display("%0t: unexpected result: kind %0d byte %02h length %0d last %0b",
                         $time, got.kind, got.data_byte, got.declared_length, got.last);
                errors++;
                return;
            end
            want = expected_q.pop_front();
            if (got.kind !== want.kind)
            begin
                $display("%0t: kind: expected %0d, actual %0d", $time, want.kind, got.kind);
                errors++;
            end
            if (got.data_byte !== want.data_byte)
            begin
                $display("%0t: data_byte: expected %02h, actual %02h",
                         $time, want.data_byte, got.data_byte);
                errors++;
            end
            if (got.declared_length !== want.declared_length)
            begin
                $display("%0t: declared_length: expected %0d, actual %0d",
                         $time, want.declared_length, got.declared_length);
                errors++;
            end
            if (got.last !== want.last)
            begin
                $display("%0t: last: expected %0b, actual %0b", $time, want.last, got.last);
                errors++;
            end
        endfunction
    endclass

    logic      clk;
    logic      rst_n;
    logic      in_valid;
    logic      in_ready;
    in_item_t  in_data;
    logic      out_valid;
    logic      out_ready;
    out_item_t out_data;

    profile_scoreboard sb;
    int                send_idle;
    int                recv_idle;
    int                items_sent;
    int                stall_cycles;

    hex_text_profile_decoder dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    // A character that is neither blank nor a digit nor a lowercase hex letter.
    function automatic logic [7:0] noise_char();
        logic [7:0] c;
        do
            c = 8'($urandom_range(1, 255));
        while (c == CHAR_SPACE || c == CHAR_NL || (c >= CHAR_0 && c <= CHAR_9)
               || (c >= CHAR_A && c <= CHAR_F));
        return c;
    endfunction

    task automatic send_char(logic [7:0] c, logic s);
        in_item_t it;
        it.text_char = c;
        it.start_req = s;
        while ($urandom_range(99) < send_idle)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
        end
        @(negedge clk);
        in_valid <= 1'b1;
        in_data  <= it;
        do
            @(posedge clk);
        while (!in_ready);
        // characters the idle decoder drops do not count toward the target
        if (s || sb.phase != PH_IDLE)
            items_sent++;
        sb.note_input(it);
    endtask

    task automatic send_str(string txt);
        int i;
        for (i = 0; i < txt.len(); i++)
            send_char(txt[i], 1'b0);
    endtask

    // Mostly well-formed profiles; some are cut by a NUL, some abandoned for a new start.
    task automatic send_profile();
        int unsigned shape;
        int unsigned cut_stage;
        int unsigned count;
        int unsigned nibbles;
        int unsigned cut_pos;
        int          i;
        bit          big;
        logic [7:0]  c;
        logic [3:0]  nib;
        string       digit_text;
        shape     = $urandom_range(99);
        cut_stage = ($urandom_range(99) < 15) ? $urandom_range(1, 5) : 0;
        big       = 1'b0;
        if (shape < 6)
        begin
            repeat ($urandom_range(1, 10))
                send_char(8'($urandom_range(255)), $urandom_range(9) == 0);
            return;
        end
        send_char(8'($urandom_range(255)), 1'b1);
        repeat ($urandom_range(0, 4))
        begin
            do
                c = 8'($urandom_range(1, 255));
            while (c == CHAR_NL);
            send_char(c, 1'b0);
        end
        if (cut_stage == 1)
        begin
            send_char(CHAR_NUL, 1'b0);
            return;
        end
        send_char(CHAR_NL, 1'b0);
        repeat ($urandom_range(0, 3))
            send_char(BLANKS[$urandom_range(2)], 1'b0);

        if (shape < 12)
        begin
            count      = 0;
            digit_text = "";
        end
        else if (shape < 17)
        begin
            count      = 0;
            digit_text = "0";
            if ($urandom_range(1))
                digit_text = "000";
        end
        else if (shape < 22)
        begin
            big        = 1'b1;
            count      = COUNT_MAX;
            digit_text = $sformatf("%0d", $urandom_range(16777215, 999999999));
        end
        else
        begin
            count      = ($urandom_range(9) == 0) ? $urandom_range(7, 40) : $urandom_range(1, 6);
            digit_text = $sformatf("%0d", count);
            if ($urandom_range(4) == 0)
                digit_text = {"0", digit_text};
        end

        if (cut_stage == 2 && digit_text.len() > 0)
        begin
            send_char(digit_text[0], 1'b0);
            send_char(CHAR_NUL, 1'b0);
            return;
        end
        send_str(digit_text);
        // with no digits, a junk character is what leaves the blank skipping
        repeat ($urandom_range(0, 2) + (shape < 12))
            send_char(noise_char(), 1'b0);
        if (cut_stage == 3)
        begin
            send_char(CHAR_NUL, 1'b0);
            return;
        end
        send_char($urandom_range(1) ? CHAR_SPACE : CHAR_NL, 1'b0);

        if (count != 0)
        begin
            nibbles = big ? $urandom_range(1, 8) : 2 * count;
            cut_pos = $urandom_range(0, nibbles - 1);
            for (i = 0; i < nibbles; i++)
            begin
                if (cut_stage >= 4 && i == cut_pos)
                begin
                    if (cut_stage == 4)
                        send_char(CHAR_NUL, 1'b0);
                    return;
                end
                if ($urandom_range(7) == 0)
                    send_char(($urandom_range(3) == 0) ? BLANKS[$urandom_range(1, 2)]
                                                       : noise_char(), 1'b0);
                nib = 4'($urandom_range(15));
                send_char((nib < 10) ? CHAR_0 + nib : CHAR_A + nib - 8'd10, 1'b0);
            end
        end
        repeat ($urandom_range(0, 2))
            send_char(8'($urandom_range(255)), 1'b0);
    endtask

    always @(negedge clk)
        out_ready <= ($urandom_range(99) >= recv_idle);

    always @(posedge clk)
    begin
        if (out_valid && out_ready)
            sb.check_result(out_data);
        if ((in_valid && in_ready) || (out_valid && out_ready))
            stall_cycles <= 0;
        else if (stall_cycles >= STALL_LIMIT)
        begin
            $display("%0t: no item moved for %0d cycles", $time, STALL_LIMIT);
            $display("CHECKS FAILED");
            $finish;
        end
        else
            stall_cycles <= stall_cycles + 1;
    end

    initial
    begin
        sb           = new;
        rst_n        = 1'b0;
        in_valid     = 1'b0;
        in_data      = '0;
        out_ready    = 1'b0;
        send_idle    = 10;
        recv_idle    = 69;
        items_sent   = 0;
        stall_cycles = 0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed: idle character, saturated count, abort by start,
        // no digits, NUL among blanks, junk and NUL in data
        send_char(8'hff, 1'b0);
        send_char("#", 1'b1);
        send_str("\n ");
        send_char(CHAR_NUL, 1'b0);
        send_str("99999999\nf0");
        send_char(CHAR_NUL, 1'b1);
        send_str("\nx ");
        send_char("#", 1'b1);
        send_str("\n01 zA");
        send_char(CHAR_NUL, 1'b0);
        send_char("#", 1'b1);
        send_str("\n1 9a");

        while (items_sent < ITEM_TARGET)
        begin
            if (items_sent >= 2 * ITEM_TARGET / 3)
            begin
                send_idle = 0;
                recv_idle = 0;
            end
            else if (items_sent >= ITEM_TARGET / 3)
            begin
                send_idle = 69;
                recv_idle = 10;
            end
            send_profile();
        end
        @(negedge clk);
        in_valid <= 1'b0;

        while (sb.expected_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (sb.errors == 0 && sb.expected_q.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/htpd_pkg.sv
rtl/htpd_step.sv
rtl/hex_text_profile_decoder.sv
rtl/htpd_checker.sv
verif/hex_text_profile_decoder_tb.sv
